[rtl/cdte_pkg.sv]
// Package for the calendar date to epoch time block: constants, types and tables.
`default_nettype none

package cdte_pkg;

  // Field widths of the request and result.
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned SecW    = 32;
  localparam int unsigned UsecW   = 52;

  // Width of the whole-year day accumulator (4095 - 1970 years of 366 days fits).
  localparam int unsigned YearDaysW = 20;

  localparam logic [YearW-1:0] BaseYear    = YearW'(1970);
  localparam logic [8:0]       DaysInYear  = 9'd365;
  localparam logic [16:0]      SecsPerDay  = 17'd86400;
  localparam logic [11:0]      SecsPerHour = 12'd3600;
  localparam logic [5:0]       SecsPerMin  = 6'd60;
  localparam logic [19:0]      UsecPerSec  = 20'd1000000;

  // Year mod 25 through a reciprocal: q = (y * Recip25) >> Recip25Shift is exact
  // for every 12-bit year.
  localparam logic [17:0]      Recip25      = 18'd167773;
  localparam int unsigned      Recip25Shift = 22;
  localparam logic [4:0]       Div25        = 5'd25;

  // Base year residues for the running leap counters (1970 mod 4, 100, 400).
  localparam logic [1:0] BaseMod4   = 2'd2;
  localparam logic [6:0] BaseMod100 = 7'd70;
  localparam logic [8:0] BaseMod400 = 9'd370;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_LEAP,
    ST_YEARS,
    ST_DAYS,
    ST_SECS,
    ST_MICRO,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic recip;
    logic leap;
    logic year_step;
    logic days;
    logic secs;
    logic micro;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic years_done;
    logic out_free;
  } status_t;

  // Days before the first of the month; codes outside 1..12 give none.
  function automatic logic [8:0] days_ahead(input logic [MonthW-1:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/cdte_if.sv]
// Valid/ready channels for the date request and the epoch time result.
`default_nettype none

interface cdte_date_if;
  logic                            valid;
  logic                            ready;
  logic [cdte_pkg::YearW-1:0]      year;
  logic [cdte_pkg::MonthW-1:0]     month;
  logic [cdte_pkg::DayW-1:0]       day_of_month;
  logic [cdte_pkg::HourW-1:0]      hour;
  logic [cdte_pkg::MinuteW-1:0]    minute;
  logic [cdte_pkg::SecondW-1:0]    second;

  modport source (output valid, year, month, day_of_month, hour, minute, second,
                  input ready);
  modport sink (input valid, year, month, day_of_month, hour, minute, second,
                output ready);
endinterface

interface cdte_epoch_if;
  logic                        valid;
  logic                        ready;
  logic [cdte_pkg::SecW-1:0]   epoch_seconds;
  logic [cdte_pkg::UsecW-1:0]  epoch_microseconds;

  modport source (output valid, epoch_seconds, epoch_microseconds, input ready);
  modport sink (input valid, epoch_seconds, epoch_microseconds, output ready);
endinterface

`default_nettype wire

[rtl/cdte_ctrl.sv]
// Controller state machine that sequences one conversion through the datapath.
`default_nettype none

module cdte_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cdte_pkg::status_t status,
  output cdte_pkg::cmd_t         cmd
);

  cdte_pkg::state_t state;
  cdte_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdte_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cdte_pkg::ST_IDLE: begin
        if (in_valid) state_next = cdte_pkg::ST_RECIP;
      end
      cdte_pkg::ST_RECIP: state_next = cdte_pkg::ST_LEAP;
      cdte_pkg::ST_LEAP:  state_next = cdte_pkg::ST_YEARS;
      cdte_pkg::ST_YEARS: begin
        if (status.years_done) state_next = cdte_pkg::ST_DAYS;
      end
      cdte_pkg::ST_DAYS:  state_next = cdte_pkg::ST_SECS;
      cdte_pkg::ST_SECS:  state_next = cdte_pkg::ST_MICRO;
      cdte_pkg::ST_MICRO: state_next = cdte_pkg::ST_HOLD;
      cdte_pkg::ST_HOLD: begin
        if (status.out_free) state_next = cdte_pkg::ST_IDLE;
      end
      default: state_next = cdte_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      cdte_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cdte_pkg::ST_RECIP: cmd.recip = 1'b1;
      cdte_pkg::ST_LEAP:  cmd.leap  = 1'b1;
      cdte_pkg::ST_YEARS: cmd.year_step = !status.years_done;
      cdte_pkg::ST_DAYS:  cmd.days  = 1'b1;
      cdte_pkg::ST_SECS:  cmd.secs  = 1'b1;
      cdte_pkg::ST_MICRO: cmd.micro = 1'b1;
      cdte_pkg::ST_HOLD:  cmd.publish = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/cdte_dp.sv]
// Datapath: year walk, day and second sums, microsecond scaling and result register.
`default_nettype none

module cdte_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [cdte_pkg::YearW-1:0]     year,
  input  wire logic [cdte_pkg::MonthW-1:0]    month,
  input  wire logic [cdte_pkg::DayW-1:0]      day_of_month,
  input  wire logic [cdte_pkg::HourW-1:0]     hour,
  input  wire logic [cdte_pkg::MinuteW-1:0]   minute,
  input  wire logic [cdte_pkg::SecondW-1:0]   second,
  input  wire cdte_pkg::cmd_t                 cmd,
  output cdte_pkg::status_t                   status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cdte_pkg::SecW-1:0]           epoch_seconds,
  output logic [cdte_pkg::UsecW-1:0]          epoch_microseconds
);

  // Captured request.
  logic [cdte_pkg::YearW-1:0]   year_r;
  logic [cdte_pkg::MonthW-1:0]  month_r;
  logic [cdte_pkg::DayW-1:0]    day_r;
  logic [cdte_pkg::HourW-1:0]   hour_r;
  logic [cdte_pkg::MinuteW-1:0] minute_r;
  logic [cdte_pkg::SecondW-1:0] second_r;

  // Leap test of the requested year.
  logic [7:0]                   quot25;
  logic                         leap_req;

  // Year walk.
  logic [cdte_pkg::YearW-1:0]   walk_year;
  logic [1:0]                   walk_mod4;
  logic [6:0]                   walk_mod100;
  logic [8:0]                   walk_mod400;
  logic [cdte_pkg::YearDaysW-1:0] year_days;

  logic [cdte_pkg::SecW-1:0]    total_days;
  logic [cdte_pkg::SecW-1:0]    secs;
  logic [cdte_pkg::UsecW-1:0]   usec_stage;

  logic [29:0]                  recip_prod;
  logic [12:0]                  quot25_x25;
  logic [4:0]                   rem25;
  logic                         leap_calc;
  logic                         walk_leap;
  logic                         leap_add;
  logic [48:0]                  day_secs_prod;
  logic [17:0]                  hms_secs;
  logic [51:0]                  usec_prod;

  // Quotient by 25 through the reciprocal, registered before its use.
  assign recip_prod = 30'(year_r) * 30'(cdte_pkg::Recip25);

  // Remainder by 25 and the Gregorian rule for the requested year.
  assign quot25_x25 = 13'(quot25) * 13'(cdte_pkg::Div25);
  assign rem25      = 5'(13'(year_r) - quot25_x25);
  assign leap_calc  = (year_r[1:0] == 2'd0) && ((rem25 != 5'd0) || (year_r[3:0] == 4'd0));

  // Gregorian rule for the year being walked, from running residues.
  assign walk_leap = (walk_mod4 == 2'd0) && ((walk_mod100 != 7'd0) || (walk_mod400 == 9'd0));

  // Leap day counts only after February of a leap year.
  assign leap_add = leap_req && (month_r > 4'd2) && (month_r <= 4'd12);

  assign day_secs_prod = 49'(total_days) * 49'(cdte_pkg::SecsPerDay);
  assign hms_secs      = 18'(second_r)
                       + 18'(minute_r) * 18'(cdte_pkg::SecsPerMin)
                       + 18'(hour_r) * 18'(cdte_pkg::SecsPerHour);
  assign usec_prod     = 52'(secs) * 52'(cdte_pkg::UsecPerSec);

  assign status.years_done = (walk_year >= year_r);
  assign status.out_free   = !out_valid || out_ready;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r   <= year;
      month_r  <= month;
      day_r    <= day_of_month;
      hour_r   <= hour;
      minute_r <= minute;
      second_r <= second;
    end
  end

  // Leap test of the requested year: the quotient by 25 is registered first, then the leap flag.
  always_ff @(posedge clk) begin
    if (cmd.recip) begin
      quot25 <= 8'(recip_prod >> cdte_pkg::Recip25Shift);
    end
    if (cmd.leap) begin
      leap_req <= leap_calc;
    end
  end

  // Walk from the base year, one year per cycle, adding 365 or 366 days.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      walk_year   <= cdte_pkg::BaseYear;
      walk_mod4   <= cdte_pkg::BaseMod4;
      walk_mod100 <= cdte_pkg::BaseMod100;
      walk_mod400 <= cdte_pkg::BaseMod400;
      year_days   <= '0;
    end else if (cmd.year_step) begin
      walk_year   <= walk_year + 1'b1;
      walk_mod4   <= walk_mod4 + 1'b1;
      walk_mod100 <= (walk_mod100 == 7'd99) ? 7'd0 : walk_mod100 + 1'b1;
      walk_mod400 <= (walk_mod400 == 9'd399) ? 9'd0 : walk_mod400 + 1'b1;
      year_days   <= year_days + cdte_pkg::YearDaysW'(cdte_pkg::DaysInYear)
                   + cdte_pkg::YearDaysW'(walk_leap);
    end
  end

  // Day total, seconds and microseconds, all modulo the register widths.
  always_ff @(posedge clk) begin
    if (cmd.days) begin
      total_days <= 32'(year_days) + 32'(cdte_pkg::days_ahead(month_r))
                  + 32'(leap_add) + 32'(day_r) - 32'd1;
    end
    if (cmd.secs) begin
      secs <= day_secs_prod[31:0] + 32'(hms_secs);
    end
    if (cmd.micro) begin
      usec_stage <= usec_prod;
    end
  end

  // Result register; it frees itself when the receiver takes the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result data changes only when a new result is published, so it holds
  // steady while the receiver stalls.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      epoch_microseconds <= usec_stage;
      epoch_seconds      <= secs;
    end
  end

endmodule

`default_nettype wire

[rtl/calendar_date_to_epoch_time.sv]
// Top level: calendar date and time to seconds and microseconds since 1970.
//
// A request on the date channel carries year, month, day of month, hour,
// minute and second. One result per request leaves on the epoch channel with
// the seconds since 1970-01-01 00:00:00 (modulo 2^32) and that count times one
// million. Both channels use valid/ready; a transfer happens on a clock edge
// where both are high.
//
// The datapath walks the whole years from 1970 one per cycle, so the time from
// acceptance to a valid result grows with the year; years up to 1970 need no
// walk. A new request is taken in the cycle after the result is placed in the
// output register, and not while the previous request is still being computed.
//
// The result register holds its value while the receiver stalls. The next
// request is then accepted and computed, and waits in the final step until
// the output register is free.
//
// Synchronous reset returns the controller to idle and empties the result
// register; no other state needs clearing.
`default_nettype none

module calendar_date_to_epoch_time (
  input  wire logic     clk,
  input  wire logic     rst,
  cdte_date_if.sink     date,
  cdte_epoch_if.source  epoch
);

  cdte_pkg::cmd_t    cmd;
  cdte_pkg::status_t status;

  cdte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (date.valid),
    .in_ready (date.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cdte_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .year               (date.year),
    .month              (date.month),
    .day_of_month       (date.day_of_month),
    .hour               (date.hour),
    .minute             (date.minute),
    .second             (date.second),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (epoch.valid),
    .out_ready          (epoch.ready),
    .epoch_seconds      (epoch.epoch_seconds),
    .epoch_microseconds (epoch.epoch_microseconds)
  );

endmodule

`default_nettype wire
